@@ rtl/drpr_pkg.sv @@
// Shared constants, command codes and the arctangent table for the path recorder.
// No dependencies; the other rtl files and the testbench import this package.
package drpr_pkg;

	localparam int POINT_CAPACITY = 256;
	localparam int CORDIC_STEPS   = 16;

	localparam int ATAN_LEN = 24;
	localparam int N_ITER   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int IT_W     = $clog2(N_ITER);
	localparam int CNT_W    = $clog2(POINT_CAPACITY + 1);

	// datapath widths
	localparam int POS_W   = 48;          // Q32.16 position
	localparam int VEC_W   = 50;          // CORDIC x/y, Q.30
	localparam int Z_W     = 34;          // residual angle, 2^32 per turn
	localparam int STEP_SH = 14;          // Q.30 -> Q.16
	localparam int D_W     = VEC_W - STEP_SH;
	localparam int PROD_W  = 46;          // 16-bit steps times 30-bit gain

	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	// command codes
	localparam logic [2:0] ACT_FWD   = 3'd0;
	localparam logic [2:0] ACT_BACK  = 3'd1;
	localparam logic [2:0] ACT_LEFT  = 3'd2;
	localparam logic [2:0] ACT_RIGHT = 3'd3;
	localparam logic [2:0] ACT_CLEAR = 3'd4;

	// atan(2^-i), 2^32 units per turn
	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/drpr_cordic.sv @@
// Iterative rotation-mode CORDIC: one shift/add step per cycle, gain preloaded.
// Depends on drpr_pkg. Returns the Q.16 step vector along the given heading.
module drpr_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [15:0]                        distance,
	input  logic [15:0]                        heading,
	output logic                               done,
	output logic signed [drpr_pkg::D_W-1:0]    dx,
	output logic signed [drpr_pkg::D_W-1:0]    dy
);
	import drpr_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_ITER = 3'b010,
		C_FIN  = 3'b100
	} cst_t;

	cst_t                    state_q;
	logic [IT_W-1:0]         iter_q;
	logic signed [VEC_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]   z_q;
	logic                    flip_q;
	logic signed [D_W-1:0]   dx_q, dy_q;
	logic                    done_q;

	logic                    fold;
	logic [15:0]             h_fold;
	logic [PROD_W-1:0]       prod;
	logic signed [VEC_W-1:0] xs, ys, x_n, y_n, xf, yf, xsh, ysh;
	logic signed [Z_W-1:0]   at, z_n;

	// fold the left half-plane onto the right and negate at the end
	assign fold   = (heading >= 16'd16384) && (heading < 16'd49152);
	assign h_fold = fold ? (heading - 16'd32768) : heading;
	assign prod   = distance * GAIN_Q30;

	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign at = {{(Z_W-32){1'b0}}, atan_lut(5'(iter_q))};

	always_comb begin
		if (!z_q[Z_W-1]) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - at;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + at;
		end
	end

	assign xf  = flip_q ? -x_q : x_q;
	assign yf  = flip_q ? -y_q : y_q;
	assign xsh = xf >>> STEP_SH;
	assign ysh = yf >>> STEP_SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						iter_q  <= '0;
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (iter_q == IT_W'(N_ITER - 1)) begin
						state_q <= C_FIN;
					end
					iter_q <= iter_q + 1'b1;
				end
				C_FIN: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			x_q    <= {{(VEC_W-PROD_W){1'b0}}, prod};
			y_q    <= '0;
			z_q    <= {{(Z_W-32){h_fold[15]}}, h_fold, 16'h0000};
			flip_q <= fold;
		end else if (state_q == C_ITER) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
		if (state_q == C_FIN) begin
			dx_q <= xsh[D_W-1:0];
			dy_q <= ysh[D_W-1:0];
		end
	end

	assign done = done_q;
	assign dx   = dx_q;
	assign dy   = dy_q;

endmodule

@@ rtl/dead_reckoning_path_recorder.sv @@
// Dead-reckoning path recorder: command decode, position update, output register.
// Depends on drpr_pkg and drpr_cordic.
//
// Usage
//   Input channel (in_valid / in_stall) carries one command request:
//   forward, backward, turn left, turn right or clear points. The block
//   raises in_stall while a move is in progress; turns, clears and unused
//   codes complete in the accept cycle, so they can follow back to back.
//   A move runs through these steps from its accept to the next accept:
//   the accept cycle loads the gain-scaled distance, then come the CORDIC
//   steps on the shared shift/add unit, the fold and scale of the vector,
//   its hand-over, and the add into the position with 48-bit saturation.
//   Output channel (out_valid / out_stall) carries one result request per
//   move: truncated x/y, point index and recorded flag. The result sits in
//   an output register, so the next command is accepted while it waits;
//   a later move holds in its final cycle until that register is taken.
//   Reset (arst_n low) clears heading, position, point count and the output
//   valid flag; no request is pending after reset.
module dead_reckoning_path_recorder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [15:0]        distance,
	input  logic [15:0]        turn_amount,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic [7:0]         point_index,
	output logic               recorded
);
	import drpr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROT  = 3'b010,
		ST_POST = 3'b100
	} state_t;

	state_t                  state_q;
	logic [15:0]             heading_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic [CNT_W-1:0]        count_q;
	logic                    back_q;
	logic                    out_valid_q;
	logic [7:0]              idx_q;
	logic                    rec_q;

	logic                    accept;
	logic                    is_move;
	logic                    cordic_start;
	logic                    cordic_done;
	logic signed [D_W-1:0]   dx, dy;
	logic                    out_free;
	logic                    post_fire;
	logic signed [POS_W:0]   sum_x, sum_y;
	logic signed [POS_W-1:0] new_x, new_y;
	logic                    has_room;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
		logic signed [POS_W-1:0] r;
		if (v[POS_W] != v[POS_W-1]) begin
			r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	// integer part, rounded toward zero
	function automatic logic signed [31:0] trunc_int(input logic signed [POS_W-1:0] p);
		logic signed [31:0] r;
		r = p[POS_W-1:16];
		if (p[POS_W-1] && (p[15:0] != 16'h0000)) begin
			r = r + 32'sd1;
		end
		return r;
	endfunction

	assign in_stall     = (state_q != ST_IDLE);
	assign accept       = in_valid && !in_stall;
	assign is_move      = (action == ACT_FWD) || (action == ACT_BACK);
	assign cordic_start = accept && is_move;

	drpr_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cordic_start),
		.distance (distance),
		.heading  (heading_q),
		.done     (cordic_done),
		.dx       (dx),
		.dy       (dy)
	);

	// backward moves negate the already-floored step
	always_comb begin
		if (back_q) begin
			sum_x = {pos_x_q[POS_W-1], pos_x_q} - {{(POS_W+1-D_W){dx[D_W-1]}}, dx};
			sum_y = {pos_y_q[POS_W-1], pos_y_q} - {{(POS_W+1-D_W){dy[D_W-1]}}, dy};
		end else begin
			sum_x = {pos_x_q[POS_W-1], pos_x_q} + {{(POS_W+1-D_W){dx[D_W-1]}}, dx};
			sum_y = {pos_y_q[POS_W-1], pos_y_q} + {{(POS_W+1-D_W){dy[D_W-1]}}, dy};
		end
	end

	assign new_x     = sat_pos(sum_x);
	assign new_y     = sat_pos(sum_y);
	assign has_room  = (count_q < CNT_W'(POINT_CAPACITY));
	assign out_free  = !out_valid_q || !out_stall;
	assign post_fire = (state_q == ST_POST) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			heading_q   <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			count_q     <= '0;
			back_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new point replaces a taken one in the same cycle
			if (post_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (action) inside
							ACT_FWD, ACT_BACK: begin
								back_q  <= (action == ACT_BACK);
								state_q <= ST_ROT;
							end
							ACT_LEFT:  heading_q <= heading_q + turn_amount;
							ACT_RIGHT: heading_q <= heading_q - turn_amount;
							ACT_CLEAR: count_q   <= '0;
							default: ;
						endcase
					end
				end
				ST_ROT: begin
					if (cordic_done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (post_fire) begin
						pos_x_q <= new_x;
						pos_y_q <= new_y;
						if (has_room) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (post_fire) begin
			idx_q <= has_room ? 8'(count_q) : 8'h00;
			rec_q <= has_room;
		end
	end

	// position registers only change when the output register is free,
	// so the truncated point follows them directly
	assign out_valid   = out_valid_q;
	assign point_x     = trunc_int(pos_x_q);
	assign point_y     = trunc_int(pos_y_q);
	assign point_index = idx_q;
	assign recorded    = rec_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for dead_reckoning_path_recorder: directed and random commands,
// each emitted point checked against a bit-exact CORDIC dead-reckoning predictor.
// Depends on drpr_pkg and the rtl top level.
module testbench;
	import drpr_pkg::*;

	// codes the block must ignore
	localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;

	localparam int HOLD_OFF_CYCLES = 400;     // long receiver hold-off
	localparam int DRAIN_LIMIT     = 20000;   // cycles allowed for results to trickle out
	localparam int RANDOM_ITEMS    = 1200;
	localparam int TAIL_MOVES      = 40;      // full-length moves in the no-idle tail
	localparam int MAX_PRINTS      = 50;

	localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint POS_LO = -POS_HI - 1;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         action;
	logic [15:0]        distance;
	logic [15:0]        turn_amount;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic [7:0]         point_index;
	logic               recorded;

	dead_reckoning_path_recorder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.distance    (distance),
		.turn_amount (turn_amount),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.recorded    (recorded)
	);

	// one expected point, as the block should emit it
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [7:0]         index;
		logic               stored;
	} point_t;

	point_t pending_points[$];

	// predicted block state, mirrors the reset values
	logic [15:0] heading_q = '0;
	longint      pos_x_q   = 0;   // Q32.16
	longint      pos_y_q   = 0;
	int          count_q   = 0;

	int mismatches    = 0;
	bit idle_on       = 1'b1;  // random gaps on both channels
	bit hold_off_req  = 1'b0;  // asks the sink for one long stall

	// atan(2^-i), 2^32 per turn
	longint atan_turn [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MAX_PRINTS)
			$display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic longint clamp_pos(input longint v);
		if (v > POS_HI)
			return POS_HI;
		if (v < POS_LO)
			return POS_LO;
		return v;
	endfunction

	// Q.16 step vector for a move of 'steps' along heading 'hd'.
	// Headings in the back half-plane are folded by half a turn and the
	// vector negated afterwards, so the CORDIC only sees +-90 degrees.
	function automatic void heading_step(input logic [15:0] hd, input logic [15:0] steps,
			output longint step_x, output longint step_y);
		logic [15:0] h;
		logic        flip;
		longint      x, y, z, xs, ys;
		h    = hd;
		flip = (hd >= 16'd16384) && (hd < 16'd49152);
		if (flip)
			h = hd - 16'd32768;
		z = longint'($signed(h)) * 65536;
		x = longint'({48'd0, steps}) * longint'({34'd0, GAIN_Q30});
		y = 0;
		for (int i = 0; i < N_ITER; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - atan_turn[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + atan_turn[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		step_x = x >>> STEP_SH;
		step_y = y >>> STEP_SH;
	endfunction

	// Applies one accepted request to the predicted state; moves queue a point.
	function automatic void track_request(input logic [2:0] act, input logic [15:0] move_len,
			input logic [15:0] turn);
		point_t p;
		longint dx, dy;
		case (act) inside
			ACT_LEFT:  heading_q = heading_q + turn;
			ACT_RIGHT: heading_q = heading_q - turn;
			ACT_CLEAR: count_q = 0;
			ACT_FWD, ACT_BACK: begin
				heading_step(heading_q, move_len, dx, dy);
				if (act == ACT_BACK) begin
					dx = -dx;
					dy = -dy;
				end
				pos_x_q = clamp_pos(pos_x_q + dx);
				pos_y_q = clamp_pos(pos_y_q + dy);
				// signed division truncates toward zero, as the block does
				p.x = 32'(pos_x_q / 65536);
				p.y = 32'(pos_y_q / 65536);
				if (count_q < POINT_CAPACITY) begin
					p.index = 8'(count_q);
					p.stored = 1'b1;
					count_q++;
				end else begin
					p.index = '0;
					p.stored = 1'b0;
				end
				pending_points.push_back(p);
			end
			default: ;  // unused codes: no effect
		endcase
	endfunction

	// Offers one request, optionally after a short idle gap, and waits for it
	// to be taken. in_valid stays high afterward so back-to-back requests flow.
	task automatic send_request(input logic [2:0] act, input logic [15:0] move_len,
			input logic [15:0] turn);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		distance    <= move_len;
		turn_amount <= turn;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_request(act, move_len, turn);
	endtask

	// Drops the input and waits until every predicted point has been taken or DRAIN_LIMIT is reached.
	task automatic wait_drained();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pending_points.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
	endtask

	// Result sink stall: random short bursts, or one long hold-off on request.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Point checker: every taken result is matched against the oldest prediction.
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected point, x", point_x, 0);
			end else begin
				want = pending_points.pop_front();
				if (point_x !== want.x)
					report_mismatch("point_x", point_x, want.x);
				if (point_y !== want.y)
					report_mismatch("point_y", point_y, want.y);
				if (point_index !== want.index)
					report_mismatch("point_index", point_index, want.index);
				if (recorded !== want.stored)
					report_mismatch("recorded", recorded, want.stored);
			end
		end
	end

	// Distance extremes and every quadrant boundary of the heading fold.
	task automatic test_directed_moves();
		send_request(ACT_FWD, 16'hFFFF, 16'h0000);
		send_request(ACT_BACK, 16'd1, 16'hFFFF);
		send_request(ACT_FWD, 16'd0, 16'h0000);
		send_request(ACT_LEFT, 16'h0000, 16'd16383);
		send_request(ACT_FWD, 16'd1000, 16'h0000);
		send_request(ACT_LEFT, 16'h0000, 16'd1);        // exactly a quarter turn
		send_request(ACT_FWD, 16'd777, 16'h0000);
		send_request(ACT_LEFT, 16'h0000, 16'd32767);    // last folded heading
		send_request(ACT_BACK, 16'd300, 16'h0000);
		send_request(ACT_LEFT, 16'h0000, 16'd1);        // first unfolded heading again
		send_request(ACT_FWD, 16'hFFFF, 16'h0000);
		send_request(ACT_RIGHT, 16'h0000, 16'd16384);   // quarter turn
		send_request(ACT_FWD, 16'd12345, 16'h0000);
		send_request(ACT_LEFT, 16'hFFFF, 16'hFFFF);     // wraps past a full turn
		send_request(ACT_BACK, 16'hFFFF, 16'h0000);
		send_request(ACT_RIGHT, 16'h0000, 16'h0000);
		send_request(ACT_RIGHT, 16'h0000, 16'hFFFF);    // wraps below zero
		send_request(ACT_FWD, 16'd2, 16'h0000);
	endtask

	task automatic test_ignored_codes();
		send_request(ACT_FIRST_UNUSED, 16'hFFFF, 16'hFFFF);
		send_request(ACT_FIRST_UNUSED + 3'd1, 16'h0000, 16'h0000);
		send_request(ACT_LAST_UNUSED, 16'($urandom), 16'($urandom));
		send_request(ACT_FWD, 16'd50, 16'h0000);
	endtask

	// Clear keeps heading and position, restarts the index.
	task automatic test_clear();
		send_request(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
		send_request(ACT_FWD, 16'd5, 16'h0000);
	endtask

	// Fill past capacity: index runs to the top, then recorded drops.
	task automatic test_capacity();
		send_request(ACT_CLEAR, 16'h0000, 16'h0000);
		for (int i = 0; i < POINT_CAPACITY + 4; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_request(ACT_LEFT, 16'h0000, 16'($urandom));
			send_request($urandom_range(0, 1) ? ACT_FWD : ACT_BACK,
				16'($urandom_range(0, 255)), 16'h0000);
		end
		send_request(ACT_CLEAR, 16'h0000, 16'h0000);
		send_request(ACT_FWD, 16'd9, 16'h0000);
	endtask

	task automatic test_random();
		int          sent;
		int          r;
		logic [2:0]  act;
		logic [15:0] move_len;
		logic [15:0] turn;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// stretches with and without idling, chosen at random
			if (sent % 200 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 399) == 0)
				act = ACT_CLEAR;   // rare, so the count often reaches capacity
			else if (r < 36)
				act = ACT_FWD;
			else if (r < 56)
				act = ACT_BACK;
			else if (r < 75)
				act = ACT_LEFT;
			else if (r < 94)
				act = ACT_RIGHT;
			else
				act = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: move_len = 16'h0000;
					1: move_len = 16'h0001;
					2: move_len = 16'hFFFE;
					default: move_len = 16'hFFFF;
				endcase
			end else begin
				move_len = 16'($urandom);
			end
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 4))
					0: turn = 16'd16384;
					1: turn = 16'd32768;
					2: turn = 16'd8192;
					3: turn = 16'h0000;
					default: turn = 16'hFFFF;
				endcase
			end else begin
				turn = 16'($urandom);
			end
			send_request(act, move_len, turn);
			if (act < ACT_FIRST_UNUSED)
				sent++;
		end
		idle_on = 1'b1;
	endtask

	// Sink holds off while moves keep coming: output register fills and the
	// next move parks, so in_stall stays up. Then the source waits for all points.
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_request($urandom_range(0, 1) ? ACT_FWD : ACT_BACK, 16'($urandom), 16'h0000);
		wait_drained();
		send_request(ACT_LEFT, 16'h0000, 16'($urandom));
		send_request(ACT_FWD, 16'($urandom), 16'h0000);
	endtask

	// Full-speed tail: long moves back to back, no idling from here on.
	task automatic test_full_speed();
		idle_on = 1'b0;
		send_request(ACT_CLEAR, 16'h0000, 16'h0000);
		send_request(ACT_RIGHT, 16'h0000, heading_q);   // back to heading zero
		for (int i = 0; i < TAIL_MOVES; i++)
			send_request(ACT_FWD, 16'hFFFF, 16'h0000);
		send_request(ACT_BACK, 16'd3, 16'h0000);
		send_request(ACT_FWD, 16'hFFFF, 16'h0000);
		send_request(ACT_LEFT, 16'h0000, 16'd16384);
		send_request(ACT_FWD, 16'hFFFF, 16'h0000);
		send_request(ACT_BACK, 16'hFFFF, 16'h0000);
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		action      <= ACT_FWD;
		distance    <= '0;
		turn_amount <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_moves();
		test_ignored_codes();
		test_clear();
		test_capacity();
		test_random();
		test_backpressure();
		test_full_speed();

		in_valid <= 1'b0;
		wait_drained();
		if (pending_points.size() != 0)
			report_mismatch("points never emitted", 0, pending_points.size());
		// watch a little longer for stray results
		repeat (N_ITER + 8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ dead_reckoning_path_recorder.f @@
rtl/drpr_pkg.sv
rtl/drpr_cordic.sv
rtl/dead_reckoning_path_recorder.sv
tb/sv/testbench.sv
